### sv/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/bpe_pkg.sv
package bpe_pkg;

	localparam int MaxPoints = 64;
	localparam int FracBits  = 16;
	localparam int IdxW      = $clog2(MaxPoints);
	localparam int CntW      = 7;
	localparam int TW        = FracBits + 1;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_EVAL  = 2'd1,
		OP_SEG   = 2'd2,
		OP_HIT   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_ANCHOR = 2'd0,
		KIND_IN     = 2'd1,
		KIND_OUT    = 2'd2
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEGMUL,
		ST_SEGSEL,
		ST_RD0,
		ST_RD1,
		ST_LOAD,
		ST_LERP,
		ST_HRD,
		ST_HCHK,
		ST_HSQ,
		ST_HCMP,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]        operation;
		logic [5:0]        point_index;
		logic signed [31:0] anchor_x;
		logic signed [31:0] anchor_y;
		logic signed [31:0] in_handle_x;
		logic signed [31:0] in_handle_y;
		logic signed [31:0] out_handle_x;
		logic signed [31:0] out_handle_y;
		logic [16:0]       t_param;
		logic signed [31:0] probe_x;
		logic signed [31:0] probe_y;
		logic [30:0]       radius;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic              hit_found;
		logic [5:0]        hit_index;
		logic [1:0]        hit_kind;
	} out_item_t;

endpackage

### sv/bezier_path_evaluator_top.sv
// Piecewise cubic Bezier path evaluator with point hit test.
// Input channel in_valid/in_ready carries in_item_t; output channel
// out_valid/out_ready carries out_item_t. cfg_we/cfg_wdata loads point_count
// (write only while idle). Writes (operation 0) store one path point at the
// transfer and give no result; the block is ready again the next cycle.
// A segment evaluation reads two entries (RD0, RD1, LOAD) and runs six
// de Casteljau steps per axis, x then y, through one shared 33x17 multiplier
// (LERP); DONE then moves the result to the output register and returns to
// idle. A global t first passes SEGMUL and SEGSEL for the segment number.
// Evaluations with fewer than two points or a bad segment go straight to DONE.
// A hit test walks entries from the highest down: one read (HRD) per entry,
// then per point a check (HCHK) and a compare (HCMP), with the two squarings
// (HSQ) through one shared multiplier between them unless a quick reject
// skips them. in_ready is low while an item is in work; a
// finished result moves to the output register, so the next input is taken
// while it waits. If the receiver stalls, the result holds there and the
// next result waits in its last state. Reset clears point_count and the
// control state; the point table is not cleared.
module bezier_path_evaluator_top import bpe_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  in_item_t         in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output out_item_t        out_data,
	input  logic             cfg_we,
	input  logic [CntW-1:0]  cfg_wdata
);
`include "assert_macros.svh"

	// memory: six coordinates per entry in one word
	logic [191:0] mem_q [MaxPoints];
	logic [191:0] rd_q;
	logic [IdxW-1:0] raddr;
	logic rd_en;

	state_t st_q, st_d;
	in_item_t item_q;
	logic [CntW-1:0] cnt_q;
	logic [IdxW:0] used;
	logic [16:0] t_q;
	logic [IdxW-1:0] seg_q;
	logic [IdxW:0] hi_q;     // next entry + 1 for hit walk
	logic [1:0] kind_q;
	logic [3:0] step_q;      // lerp step 0..5 within one axis
	logic axis_q;            // 0 x, 1 y
	logic signed [31:0] p_q [4]; // de Casteljau points, current axis
	logic signed [31:0] ay_q [4]; // y points held during x pass
	logic signed [31:0] res_x_q;
	logic [33:0] dx_q, dy_q;
	logic sq_ph_q;
	logic [63:0] sqx_q, sqy_q, rr_q;
	out_item_t res_q;
	out_item_t out_q;
	logic res_v_q;

	assign used = (cnt_q > CntW'(MaxPoints)) ? (IdxW+1)'(MaxPoints) : cnt_q[IdxW:0];

	always_ff @(posedge clk) begin
		if (in_valid && in_ready && op_t'(in_data.operation) == OP_WRITE)
			mem_q[in_data.point_index[IdxW-1:0]] <= {in_data.anchor_x, in_data.anchor_y,
				in_data.in_handle_x, in_data.in_handle_y,
				in_data.out_handle_x, in_data.out_handle_y};
		if (rd_en)
			rd_q <= mem_q[raddr];
	end

	// shared lerp multiplier: (b-a) * t
	logic signed [32:0] diff;
	logic signed [50:0] prod;
	logic signed [50:0] rnd;
	logic signed [31:0] lerp_out;
	logic [1:0] li;   // index of a in p_q
	always_comb begin
		unique case (step_q)
			4'd0, 4'd3, 4'd5: li = 2'd0;
			4'd1, 4'd4:       li = 2'd1;
			default:          li = 2'd2;
		endcase
	end
	// step order per axis: level1 0,1,2 ; level2 3,4 ; level3 5
	assign diff = 33'(p_q[li + 2'd1]) - 33'(p_q[li]);
	assign prod = 51'(diff) * $signed({34'd0, t_q});
	assign rnd = prod + 51'sd32768;
	assign lerp_out = p_q[li] + 32'(rnd >>> FracBits);

	// hit multiplier
	logic [33:0] sq_in;
	logic [67:0] sq_prod;
	assign sq_in = sq_ph_q ? dy_q : dx_q;
	assign sq_prod = sq_in * sq_in;

	logic signed [32:0] ptx, pty;
	always_comb begin
		unique case (kind_q)
			KIND_OUT: begin ptx = 33'(signed'(rd_q[63:32]));   pty = 33'(signed'(rd_q[31:0])); end
			KIND_IN:  begin ptx = 33'(signed'(rd_q[127:96]));  pty = 33'(signed'(rd_q[95:64])); end
			default:  begin ptx = 33'(signed'(rd_q[191:160])); pty = 33'(signed'(rd_q[159:128])); end
		endcase
	end
	logic signed [32:0] ddx, ddy;
	logic [32:0] adx, ady;
	assign ddx = 33'(item_q.probe_x) - ptx;
	assign ddy = 33'(item_q.probe_y) - pty;
	assign adx = ddx[32] ? 33'(-ddx) : 33'(ddx);
	assign ady = ddy[32] ? 33'(-ddy) : 33'(ddy);
	logic quick_out;
	assign quick_out = (adx >= {2'd0, item_q.radius}) || (ady >= {2'd0, item_q.radius});
	logic [64:0] sum;
	assign sum = {1'b0, sqx_q} + {1'b0, sqy_q};

	// segment selection: t*curves
	logic [IdxW:0] curves;
	assign curves = used - (IdxW+1)'(1);
	logic [23:0] tprod;
	assign tprod = 24'(t_q) * 24'(curves);

	logic [16:0] t_in;
	assign t_in = (in_data.t_param > 17'd65536) ? 17'd65536 : in_data.t_param;

	// next state
	logic last_step;
	assign last_step = (step_q == 4'd5);
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE: if (in_valid && in_ready) begin
				unique case (op_t'(in_data.operation))
					OP_WRITE: st_d = ST_IDLE;
					OP_EVAL:  st_d = (used < (IdxW+1)'(2)) ? ST_DONE : ST_SEGMUL;
					OP_SEG:   st_d = (used < (IdxW+1)'(2) ||
						(IdxW+1)'(in_data.point_index) >= used - (IdxW+1)'(1)) ?
						ST_DONE : ST_RD0;
					default:  st_d = (used == '0) ? ST_DONE : ST_HRD;
				endcase
			end
			ST_SEGMUL: st_d = ST_SEGSEL;
			ST_SEGSEL: st_d = ST_RD0;
			ST_RD0:    st_d = ST_RD1;
			ST_RD1:    st_d = ST_LOAD;
			ST_LOAD:   st_d = ST_LERP;
			ST_LERP:   if (last_step && axis_q) st_d = ST_DONE;
			ST_HRD:    st_d = ST_HCHK;
			ST_HCHK:   st_d = quick_out ? ST_HCMP : ST_HSQ;
			ST_HSQ:    if (sq_ph_q) st_d = ST_HCMP;
			ST_HCMP:   begin
				if (!quick_out && sum < {1'b0, rr_q}) st_d = ST_DONE;
				else if (kind_q != KIND_ANCHOR) st_d = ST_HCHK;
				else if (hi_q == (IdxW+1)'(1)) st_d = ST_DONE;
				else st_d = ST_HRD;
			end
			ST_DONE:   if (!res_v_q) st_d = ST_IDLE;
			default:   st_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		rd_en = 1'b0;
		raddr = seg_q;
		unique case (st_q)
			ST_RD0: begin rd_en = 1'b1; raddr = seg_q; end
			ST_RD1: begin rd_en = 1'b1; raddr = seg_q + IdxW'(1); end
			ST_HRD: begin rd_en = 1'b1; raddr = IdxW'(hi_q - (IdxW+1)'(1)); end
			default: ;
		endcase
	end

	assign in_ready = (st_q == ST_IDLE);
	assign out_valid = res_v_q;
	assign out_data = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			cnt_q <= '0;
			res_v_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (cfg_we) cnt_q <= cfg_wdata;
			if (out_valid && out_ready) res_v_q <= 1'b0;
			if (st_q == ST_DONE && !res_v_q) res_v_q <= 1'b1;
		end
	end

	logic hit_now;
	assign hit_now = !quick_out && sum < {1'b0, rr_q};

	always_ff @(posedge clk) begin
		// radius squared computed once with the sq multiplier idle
		unique case (st_q)
			ST_IDLE: if (in_valid && in_ready) begin
				item_q <= in_data;
				t_q <= t_in;
				seg_q <= in_data.point_index;
				hi_q <= used;
				kind_q <= KIND_OUT;
				step_q <= '0;
				axis_q <= 1'b0;
				res_q <= '0;
				rr_q <= 64'({33'd0, in_data.radius} * {33'd0, in_data.radius});
			end
			ST_SEGMUL: begin
				if ((tprod >> FracBits) > 24'(curves - (IdxW+1)'(1)))
					seg_q <= IdxW'(curves - (IdxW+1)'(1));
				else
					seg_q <= IdxW'(tprod >> FracBits);
			end
			ST_SEGSEL: t_q <= 17'(tprod - (24'(seg_q) << FracBits));
			ST_RD0: ;
			ST_RD1: begin
				p_q[0] <= signed'(rd_q[191:160]);
				p_q[1] <= signed'(rd_q[63:32]);
				ay_q[0] <= signed'(rd_q[159:128]);
				ay_q[1] <= signed'(rd_q[31:0]);
			end
			ST_LOAD: begin
				p_q[2] <= signed'(rd_q[127:96]);
				p_q[3] <= signed'(rd_q[191:160]);
				ay_q[2] <= signed'(rd_q[95:64]);
				ay_q[3] <= signed'(rd_q[159:128]);
			end
			ST_LERP: begin
				// levels write in place: a'=lerp(p0,p1) into p0, etc.
				if (last_step) begin
					step_q <= '0;
					if (!axis_q) begin
						res_x_q <= lerp_out;
						axis_q <= 1'b1;
						p_q <= ay_q;
					end else begin
						res_q.point_x <= res_x_q;
						res_q.point_y <= lerp_out;
					end
				end else begin
					p_q[li] <= lerp_out;
					step_q <= step_q + 4'd1;
				end
			end
			ST_HRD: kind_q <= KIND_OUT;
			ST_HCHK: begin
				dx_q <= 34'(adx);
				dy_q <= 34'(ady);
				sq_ph_q <= 1'b0;
			end
			ST_HSQ: begin
				sq_ph_q <= ~sq_ph_q;
				if (!sq_ph_q) sqx_q <= 64'(sq_prod);
				else sqy_q <= 64'(sq_prod);
			end
			ST_HCMP: begin
				if (hit_now) begin
					res_q.hit_found <= 1'b1;
					res_q.hit_index <= 6'(hi_q - (IdxW+1)'(1));
					res_q.hit_kind <= kind_q;
				end else if (kind_q == KIND_OUT) kind_q <= KIND_IN;
				else if (kind_q == KIND_IN) kind_q <= KIND_ANCHOR;
				else hi_q <= hi_q - (IdxW+1)'(1);
			end
			ST_DONE: if (!res_v_q) out_q <= res_q;
			default: ;
		endcase
	end

	`ASSERT_IMPL(a_busy_not_ready, clk, arst_n, st_q != ST_IDLE, !in_ready, "ready while busy")
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data),
		"result lost under stall")
	`ASSERT_IMPL(a_hit_kind, clk, arst_n, out_valid && out_data.hit_found,
		out_data.point_x == 32'sd0 && out_data.point_y == 32'sd0, "hit with point")

endmodule

### bench/tb_bezier_path_evaluator_top.sv
`timescale 1ns / 100ps

module tb_bezier_path_evaluator_top;
	import bpe_pkg::*;

	localparam int WatchLimit = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;
	logic cfg_we = 1'b0;
	logic [CntW-1:0] cfg_wdata = '0;

	bezier_path_evaluator_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always #2 clk = ~clk;

	// predictor state
	logic signed [31:0] ax_tab[MaxPoints], ay_tab[MaxPoints];
	logic signed [31:0] ix_tab[MaxPoints], iy_tab[MaxPoints];
	logic signed [31:0] ox_tab[MaxPoints], oy_tab[MaxPoints];
	int unsigned path_count = 0;

	in_item_t pending_items[$];
	out_item_t expected_points[$];
	int errors = 0;
	bit no_idle = 0;
	bit hold_go = 0;
	bit hold_used = 0;
	int hold_left = 0;
	int quiet_cycles = 0;

	function automatic void queue_item(in_item_t it);
		pending_items = {pending_items, it};
	endfunction

	function automatic longint lerp_step(longint a, longint b, longint t);
		longint p;
		p = (b - a) * t + 32768;
		return a + (p >>> FracBits);
	endfunction

	function automatic longint cubic_point(longint p0, longint p1, longint p2, longint p3,
			longint t);
		longint a, b, c;
		a = lerp_step(p0, p1, t);
		b = lerp_step(p1, p2, t);
		c = lerp_step(p2, p3, t);
		return lerp_step(lerp_step(a, b, t), lerp_step(b, c, t), t);
	endfunction

	function automatic bit within_radius(longint px, longint py, longint qx, longint qy,
			longint r);
		longint dx, dy;
		dx = px - qx;
		dy = py - qy;
		if (dx < 0) dx = -dx;
		if (dy < 0) dy = -dy;
		if (dx >= r || dy >= r) return 0;
		return dx * dx + dy * dy < r * r;
	endfunction

	function automatic int unsigned used_count();
		return path_count > MaxPoints ? MaxPoints : path_count;
	endfunction

	function automatic void eval_segment(int unsigned n, longint t, inout out_item_t res);
		int unsigned cnt;
		cnt = used_count();
		if (cnt < 2 || n >= cnt - 1) return;
		res.point_x = 32'(cubic_point(ax_tab[n], ox_tab[n], ix_tab[n+1], ax_tab[n+1], t));
		res.point_y = 32'(cubic_point(ay_tab[n], oy_tab[n], iy_tab[n+1], ay_tab[n+1], t));
	endfunction

	function automatic bit predict_bezier(in_item_t it, output out_item_t res);
		longint t, prod, seg, curves;
		int unsigned cnt;
		res = '0;
		t = it.t_param;
		if (t > (1 << FracBits)) t = 1 << FracBits;
		cnt = used_count();
		case (op_t'(it.operation))
			OP_WRITE: begin
				ax_tab[it.point_index] = it.anchor_x;
				ay_tab[it.point_index] = it.anchor_y;
				ix_tab[it.point_index] = it.in_handle_x;
				iy_tab[it.point_index] = it.in_handle_y;
				ox_tab[it.point_index] = it.out_handle_x;
				oy_tab[it.point_index] = it.out_handle_y;
				return 0;
			end
			OP_EVAL: begin
				if (cnt >= 2) begin
					curves = cnt - 1;
					prod = t * curves;
					seg = prod >> FracBits;
					if (seg > curves - 1) seg = curves - 1;
					eval_segment(int'(seg), prod - (seg << FracBits), res);
				end
			end
			OP_SEG: eval_segment(it.point_index, t, res);
			default: begin
				for (int i = int'(cnt) - 1; i >= 0 && !res.hit_found; i--) begin
					if (within_radius(it.probe_x, it.probe_y, ox_tab[i], oy_tab[i], it.radius)) begin
						res.hit_found = 1;
						res.hit_kind = KIND_OUT;
					end else if (within_radius(it.probe_x, it.probe_y, ix_tab[i], iy_tab[i],
							it.radius)) begin
						res.hit_found = 1;
						res.hit_kind = KIND_IN;
					end else if (within_radius(it.probe_x, it.probe_y, ax_tab[i], ay_tab[i],
							it.radius)) begin
						res.hit_found = 1;
						res.hit_kind = KIND_ANCHOR;
					end
					if (res.hit_found) res.hit_index = 6'(i);
				end
			end
		endcase
		return 1;
	endfunction

	// driver
	always @(posedge clk) begin
		out_item_t res;
		if (cfg_we) path_count = cfg_wdata;
		if (in_valid && in_ready) begin
			if (predict_bezier(in_data, res)) expected_points = {expected_points, res};
		end
		if (!in_valid || in_ready) begin
			if (pending_items.size() > 0 && (no_idle || $urandom_range(0, 99) >= 23)) begin
				in_valid <= 1'b1;
				in_data <= pending_items.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		out_item_t exp_res;
		if (out_valid && out_ready) begin
			if (expected_points.size() == 0) begin
				$display("%0t: unexpected result %h", $time, out_data);
				errors++;
			end else begin
				exp_res = expected_points.pop_front();
				if (out_data.point_x !== exp_res.point_x || out_data.point_y !== exp_res.point_y
						|| out_data.hit_found !== exp_res.hit_found
						|| out_data.hit_index !== exp_res.hit_index
						|| out_data.hit_kind !== exp_res.hit_kind) begin
					$display("%0t: mismatch expected x=%h y=%h hit=%b idx=%0d kind=%0d",
						$time, exp_res.point_x, exp_res.point_y, exp_res.hit_found,
						exp_res.hit_index, exp_res.hit_kind);
					$display("%0t:          actual   x=%h y=%h hit=%b idx=%0d kind=%0d",
						$time, out_data.point_x, out_data.point_y, out_data.hit_found,
						out_data.hit_index, out_data.hit_kind);
					errors++;
				end
			end
		end
		if (hold_go && !hold_used) begin
			hold_used <= 1;
			hold_left <= 400;
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= no_idle || $urandom_range(0, 99) >= 23;
		end
	end

	// watchdog: cycles with no transfer on either channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WatchLimit) begin
			$display("*** FAILED ***");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0;
			3: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	function automatic in_item_t rand_item();
		in_item_t it;
		it.operation = 2'($urandom);
		it.point_index = 6'($urandom);
		it.anchor_x = rand_word();
		it.anchor_y = rand_word();
		it.in_handle_x = rand_word();
		it.in_handle_y = rand_word();
		it.out_handle_x = rand_word();
		it.out_handle_y = rand_word();
		it.t_param = 17'($urandom);
		it.probe_x = rand_word();
		it.probe_y = rand_word();
		it.radius = 31'($urandom);
		return it;
	endfunction

	function automatic in_item_t make_item(op_t op, int idx, int t);
		in_item_t it;
		it = rand_item();
		it.operation = op;
		it.point_index = 6'(idx);
		it.t_param = 17'(t);
		return it;
	endfunction

	// mostly meaningful operations for the current count
	function automatic in_item_t phase_item(int unsigned cnt);
		in_item_t it;
		int sel, e;
		it = rand_item();
		sel = $urandom_range(0, 99);
		if ($urandom_range(0, 1)) it.t_param = 17'($urandom_range(0, 1 << FracBits));
		if (sel < 15) begin
			it.operation = OP_WRITE;
		end else if (sel < 45) begin
			it.operation = OP_EVAL;
		end else if (sel < 70) begin
			it.operation = OP_SEG;
			if (cnt > 0 && $urandom_range(0, 3) != 0)
				it.point_index = 6'($urandom_range(0, cnt - 1));
		end else begin
			it.operation = OP_HIT;
			if (cnt > 0) begin
				e = $urandom_range(0, cnt - 1);
				case ($urandom_range(0, 2))
					0: begin it.probe_x = ax_tab[e]; it.probe_y = ay_tab[e]; end
					1: begin it.probe_x = ix_tab[e]; it.probe_y = iy_tab[e]; end
					default: begin it.probe_x = ox_tab[e]; it.probe_y = oy_tab[e]; end
				endcase
				it.probe_x += $signed($urandom_range(0, 4000)) - 2000;
				it.probe_y += $signed($urandom_range(0, 4000)) - 2000;
				case ($urandom_range(0, 3))
					0: it.radius = 31'($urandom_range(1, 3000));
					1: it.radius = 31'($urandom_range(0, 1 << 20));
					2: it.radius = 0;
					default: it.radius = 31'($urandom);
				endcase
			end
		end
		return it;
	endfunction

	task automatic wait_drained();
		while (pending_items.size() > 0 || in_valid || expected_points.size() > 0)
			@(posedge clk);
	endtask

	task automatic set_count(int unsigned value);
		wait_drained();
		repeat (40) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= CntW'(value);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic run_phase(int unsigned value, int n);
		int unsigned cnt;
		set_count(value);
		cnt = value > MaxPoints ? MaxPoints : value;
		for (int i = 0; i < n; i++) queue_item(phase_item(cnt));
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// empty table: evaluations give zero, hit test finds nothing
		queue_item(make_item(OP_EVAL, 0, 1 << FracBits));
		queue_item(make_item(OP_SEG, 0, 0));
		queue_item(make_item(OP_HIT, 0, 0));
		for (int i = 0; i < MaxPoints; i++) queue_item(make_item(OP_WRITE, i, 0));
		wait_drained();

		set_count(2);
		queue_item(make_item(OP_EVAL, 0, 0));
		queue_item(make_item(OP_EVAL, 0, 1 << FracBits));
		queue_item(make_item(OP_EVAL, 0, 17'h1ffff));
		queue_item(make_item(OP_SEG, 0, 32768));
		queue_item(make_item(OP_SEG, 1, 32768));
		queue_item(make_item(OP_SEG, 63, 32768));
		begin
			in_item_t it;
			it = make_item(OP_HIT, 0, 0);
			it.probe_x = ax_tab[1];
			it.probe_y = ay_tab[1];
			it.radius = 0;
			queue_item(it);
			it.radius = 31'h7fff_ffff;
			queue_item(it);
		end
		set_count(1);
		queue_item(make_item(OP_EVAL, 0, 40000));
		queue_item(make_item(OP_SEG, 0, 40000));
		set_count(127);
		queue_item(make_item(OP_EVAL, 0, 1 << FracBits));
		queue_item(make_item(OP_SEG, 62, 1 << FracBits));
		queue_item(make_item(OP_SEG, 63, 0));
		queue_item(make_item(OP_HIT, 0, 0));

		run_phase(3, 200);
		run_phase(5, 200);
		// block fills while the receiver holds off
		@(posedge clk);
		hold_go <= 1;
		run_phase(64, 120);
		no_idle = 1;
		run_phase(17, 200);
		wait_drained();
		no_idle = 0;
		run_phase(2, 200);
		run_phase(100, 100);
		run_phase(9, 200);
		run_phase(0, 30);
		run_phase(64, 60);

		wait_drained();
		repeat (50) @(posedge clk);
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
